@@ rtl/rbkc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbkc_pkg: shared definitions for the radio bridge key control
// Field widths, register map, reset values, event codes and sequencer states.
// ----------------------------------------------------------------------------
package rbkc_pkg;

    // Payload widths fixed by the event and result formats.
    localparam int MODE_W  = 2;
    localparam int PORT_W  = 4;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 5;
    localparam int DELAY_W = 16;

    // The port field can address at most this many ports.
    localparam int PORT_LIMIT        = 16;
    localparam int DEFAULT_NUM_PORTS = 16;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes (byte address divided by four).
    localparam logic REG_PORT_COUNT = 1'b0;
    localparam logic REG_HANG_DELAY = 1'b1;

    // Register reset values.
    localparam logic [CNT_W-1:0]   PORT_COUNT_RST = CNT_W'(3);
    localparam logic [DELAY_W-1:0] HANG_DELAY_RST = DELAY_W'(40);

    // Above this many ports in use the bridge runs mix-minus keying.
    localparam logic [CNT_W-1:0] MIX_MIN_PORTS = CNT_W'(2);

    // Event kinds.
    localparam logic [MODE_W-1:0] MODE_VOICE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_KEY   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNKEY = 2'd2;

    // Configuration seen by the keying sequencer.
    typedef struct packed {
        logic [CNT_W-1:0]   port_count;
        logic [DELAY_W-1:0] hang_delay_ms;
    } rbkc_cfg_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_WALK,
        ST_FLUSH
    } rbkc_state_t;

endpackage

@@ rtl/rbkc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbkc_if: valid/ready channels of the radio bridge key control
// One channel carries keying events in, the other carries transmitter commands.
// ----------------------------------------------------------------------------
interface rbkc_evt_if;
    import rbkc_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, output mode, output port, output time_ms, input ready);
    modport sink   (input valid, input mode, input port, input time_ms, output ready);
endinterface

interface rbkc_res_if;
    import rbkc_pkg::*;

    logic              valid;
    logic              ready;
    logic [PORT_W-1:0] target_port;
    logic              key_on;
    logic              last;

    modport source (output valid, output target_port, output key_on, output last,
                    input ready);
    modport sink   (input valid, input target_port, input key_on, input last,
                    output ready);
endinterface

@@ rtl/rbkc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbkc_cfg_regs: configuration registers
// APB-style register file holding the port count and the hang delay.
// ----------------------------------------------------------------------------
module rbkc_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [rbkc_pkg::PADDR_W-1:0] paddr,
    input  logic [rbkc_pkg::PDATA_W-1:0] pwdata,
    output logic [rbkc_pkg::PDATA_W-1:0] prdata,
    output logic                      pready,
    output rbkc_pkg::rbkc_cfg_t       cfg
);
    import rbkc_pkg::*;

    logic [CNT_W-1:0]   port_count_reg;
    logic [DELAY_W-1:0] hang_delay_reg;
    logic               wr_en;
    logic               reg_sel;

    // pready is tied high, so the access phase never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_count_reg <= PORT_COUNT_RST;
            hang_delay_reg <= HANG_DELAY_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_PORT_COUNT: port_count_reg <= pwdata[CNT_W-1:0];
                REG_HANG_DELAY: hang_delay_reg <= pwdata[DELAY_W-1:0];
                default:        port_count_reg <= port_count_reg;
            endcase
        end
    end

    // Read data.
    always_comb
    begin
        case (reg_sel)
            REG_PORT_COUNT: prdata = PDATA_W'(port_count_reg);
            REG_HANG_DELAY: prdata = PDATA_W'(hang_delay_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.port_count    = port_count_reg;
    assign cfg.hang_delay_ms = hang_delay_reg;

endmodule

@@ rtl/radio_bridge_key_control.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_bridge_key_control: transmitter keying for a multi-port radio bridge
// Takes key, unkey and voice events and issues key or unkey commands per port.
// ----------------------------------------------------------------------------
// Usage:
//   evt (sink) takes one event per transfer: mode, port and time_ms.
//   res (source) gives transmitter commands: target_port, key_on, and last
//   set on the final command of an event. An event with no command gives no
//   transfer on res. Registers port_count and hang_delay_ms sit on the APB
//   port at byte addresses 0 and 4; write them only while the block is idle.
//   Timing: evt.ready is high only while the sequencer is idle. An event is
//   accepted, then updates the port state, then the sequencer walks the ports
//   in use one by one, and a flush step hands off the final command. Events
//   that start no walk (an ignored event; with mix-minus keying an unkey or
//   a voice frame that ends no hang; without it any voice frame) return to
//   idle after the decision. The walk is set by the single shared evaluation
//   unit that checks one port a cycle while no stalled command holds it.
//   A command waits in an output register; when the receiver stalls, the walk
//   holds at the next port that changes, or at the final hand-off, until that
//   register is taken. Reset clears the receive, hang and keyed flags of every
//   port and loads port_count 3, hang_delay_ms 40.
// ----------------------------------------------------------------------------
module radio_bridge_key_control #(
    parameter int NUM_PORTS = rbkc_pkg::DEFAULT_NUM_PORTS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rbkc_pkg::PADDR_W-1:0] paddr,
    input  logic [rbkc_pkg::PDATA_W-1:0] pwdata,
    output logic [rbkc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    rbkc_evt_if.sink                     evt,
    rbkc_res_if.source                   res
);
    import rbkc_pkg::*;

    // Ports that can actually be stored and addressed.
    localparam int NP    = (NUM_PORTS > PORT_LIMIT) ? PORT_LIMIT : NUM_PORTS;
    localparam int IDX_W = (NP > 1) ? $clog2(NP) : 1;

    rbkc_cfg_t   cfg;
    rbkc_state_t state_reg, state_next;

    // Event captured at acceptance.
    logic [MODE_W-1:0] mode_reg;
    logic [PORT_W-1:0] port_reg;
    logic [TIME_W-1:0] time_reg;

    // Per-port state.
    logic [NP-1:0]     recv_reg, recv_next;
    logic [NP-1:0]     hang_reg, hang_next;
    logic [NP-1:0]     txk_reg, txk_next;
    logic [TIME_W-1:0] hang_start_reg [NP];
    logic              hs_we;

    // Walk counter and the command held back until the next one is known.
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]  pend_port_reg, pend_port_next;
    logic              pend_on_reg, pend_on_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_port_reg, out_port_next;
    logic              out_on_reg, out_on_next;
    logic              out_last_reg, out_last_next;

    logic [CNT_W-1:0]  n_eff;
    logic              mix;
    logic [NP-1:0]     use_mask;
    logic [NP-1:0]     others;
    logic              other_bit;
    logic              step_emit;
    logic              step_on;
    logic              walk_end;
    logic              out_free;
    logic              accept;
    logic [IDX_W-1:0]  pidx;
    logic              ignore;
    logic [TIME_W-1:0] elapsed;
    logic              hang_done;

    rbkc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Ports in use and the keying mode.
    assign n_eff = (cfg.port_count > CNT_W'(NP)) ? CNT_W'(NP) : cfg.port_count;
    assign mix   = n_eff > MIX_MIN_PORTS;

    // Shared evaluation unit: keying of the port under the walk counter.
    always_comb
    begin
        for (int i = 0; i < NP; i++)
        begin
            use_mask[i] = CNT_W'(i) < n_eff;
            others[i]   = (recv_reg[i] | hang_reg[i]) & use_mask[i] &
                          (IDX_W'(i) != idx_reg);
        end
    end

    assign other_bit = |others;
    assign step_emit = mix ? (other_bit != txk_reg[idx_reg])
                           : (idx_reg != port_reg[IDX_W-1:0]);
    assign step_on   = mix ? other_bit : (mode_reg == MODE_KEY);
    assign walk_end  = CNT_W'(idx_reg) == (n_eff - CNT_W'(1));

    // Event decode.
    assign pidx      = port_reg[IDX_W-1:0];
    assign ignore    = (CNT_W'(port_reg) >= n_eff) ||
                       !(mode_reg inside {MODE_VOICE, MODE_KEY, MODE_UNKEY});
    assign elapsed   = time_reg - hang_start_reg[pidx];
    assign hang_done = !recv_reg[pidx] && hang_reg[pidx] &&
                       (elapsed >= TIME_W'(cfg.hang_delay_ms));

    assign out_free  = !out_valid_reg || res.ready;
    assign accept    = evt.valid && evt.ready;

    assign evt.ready       = (state_reg == ST_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.target_port = PORT_W'(out_port_reg);
    assign res.key_on      = out_on_reg;
    assign res.last        = out_last_reg;

    // Sequencer: next state and register updates.
    always_comb
    begin
        state_next      = state_reg;
        recv_next       = recv_reg;
        hang_next       = hang_reg;
        txk_next        = txk_reg;
        hs_we           = 1'b0;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_port_next  = pend_port_reg;
        pend_on_next    = pend_on_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_port_next   = out_port_reg;
        out_on_next     = out_on_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                idx_next   = '0;
                state_next = ST_IDLE;
                if (!ignore)
                begin
                    if (mix)
                    begin
                        case (mode_reg)
                            MODE_KEY:
                            begin
                                recv_next[pidx] = 1'b1;
                                hang_next[pidx] = 1'b0;
                                state_next      = ST_WALK;
                            end
                            MODE_UNKEY:
                            begin
                                recv_next[pidx] = 1'b0;
                                hang_next[pidx] = 1'b1;
                                hs_we           = 1'b1;
                            end
                            MODE_VOICE:
                            begin
                                if (hang_done)
                                begin
                                    hang_next[pidx] = 1'b0;
                                    state_next      = ST_WALK;
                                end
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                    else if (mode_reg != MODE_VOICE)
                    begin
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                // A change is held until the next one shows it is not the last.
                if (!step_emit || !pend_valid_reg || out_free)
                begin
                    if (step_emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_port_next  = pend_port_reg;
                            out_on_next    = pend_on_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_port_next  = idx_reg;
                        pend_on_next    = step_on;
                        if (mix)
                        begin
                            txk_next[idx_reg] = step_on;
                        end
                    end
                    if (walk_end)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_port_next   = pend_port_reg;
                    out_on_next     = pend_on_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            recv_reg       <= '0;
            hang_reg       <= '0;
            txk_reg        <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            recv_reg       <= recv_next;
            hang_reg       <= hang_next;
            txk_reg        <= txk_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= evt.mode;
            port_reg <= evt.port;
            time_reg <= evt.time_ms;
        end
        pend_port_reg <= pend_port_next;
        pend_on_reg   <= pend_on_next;
        out_port_reg  <= out_port_next;
        out_on_reg    <= out_on_next;
        out_last_reg  <= out_last_next;
    end

    // Hang start times; only read while the port's hang is active.
    always_ff @(posedge clk)
    begin
        if (hs_we)
        begin
            hang_start_reg[pidx] <= time_reg;
        end
    end

endmodule
